@@ rtl/core/rbpc_pkg.sv @@
// Shared types, constants and helpers for the row bright-pixel centroid block.
package rbpc_pkg;

    localparam int RBPC_ROW_WIDTH_DEF = 320;
    localparam int CHAN_W             = 8;
    localparam int THRESH_W           = 8;
    localparam int LINE_COL_W         = 9;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd150;

    // 171/512 matches floor(x/3) for every 8-bit channel value
    localparam logic [8:0] DIV3_RECIP = 9'd171;
    localparam int         DIV3_SHIFT = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } rbpc_state_t;

    typedef struct packed {
        logic accept;      // take the input word, update row accumulators
        logic div_start;   // latch row totals and arm the divider
        logic div_step;    // one quotient bit
        logic load_pixel;  // load a mid-row result into the output register
        logic load_row;    // load the row-closing result into the output register
    } rbpc_cmd_t;

    typedef struct packed {
        logic div_last;    // current divider step yields the final quotient bit
    } rbpc_stat_t;

    function automatic logic [CHAN_W-1:0] div3(input logic [CHAN_W-1:0] x);
        logic [CHAN_W+8:0] prod;
        prod = {9'd0, x} * {{CHAN_W{1'b0}}, DIV3_RECIP};
        return CHAN_W'(prod >> DIV3_SHIFT);
    endfunction

endpackage

@@ rtl/core/rbpc_ctrl.sv @@
// Controller for the row bright-pixel centroid block: handshakes and sequencing.
module rbpc_ctrl
    import rbpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_row_end,
    output logic       m_valid,
    input  logic       m_ready,
    output rbpc_cmd_t  cmd,
    input  rbpc_stat_t stat
);

    rbpc_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cmd.accept = 1'b1;
                    if (s_row_end) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end else begin
                        cmd.load_pixel = 1'b1;
                        m_valid_next   = 1'b1;
                    end
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    cmd.load_row = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input ready while a row end is in progress");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_pixel || cmd.load_row) |-> (!m_valid_reg || m_ready))
        else $error("output register loaded over an undelivered word");

    a_div_to_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && stat.div_last) |=> (state_reg == ST_DELIVER))
        else $error("divider finished without moving to delivery");

endmodule

@@ rtl/core/rbpc_datapath.sv @@
// Datapath for the row bright-pixel centroid block: threshold, accumulators, divider.
module rbpc_datapath
    import rbpc_pkg::*;
#(
    parameter int ROW_WIDTH = RBPC_ROW_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [THRESH_W-1:0]   cfg_wr_data,
    input  logic [CHAN_W-1:0]     s_pix_red,
    input  logic [CHAN_W-1:0]     s_pix_green,
    input  logic [CHAN_W-1:0]     s_pix_blue,
    input  logic                  s_row_end,
    output logic [CHAN_W-1:0]     m_out_red,
    output logic [CHAN_W-1:0]     m_out_green,
    output logic [CHAN_W-1:0]     m_out_blue,
    output logic                  m_row_done,
    output logic                  m_line_found,
    output logic [LINE_COL_W-1:0] m_line_column,
    input  rbpc_cmd_t             cmd,
    output rbpc_stat_t            stat
);

    localparam int COL_W  = $clog2(ROW_WIDTH + 1);
    localparam int SUM_W  = $clog2(ROW_WIDTH * (ROW_WIDTH - 1) / 2 + 1);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [THRESH_W-1:0] thresh_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COL_W-1:0]    cnt_reg, cnt_next;

    logic [CHAN_W-1:0]   hold_red_reg, hold_green_reg, hold_blue_reg;
    logic [COL_W-1:0]    div_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [COL_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [CHAN_W+1:0]   bright;
    logic                dark, in_row, counted;
    logic [CHAN_W-1:0]   th_red, th_green, th_blue;
    logic [COL_W:0]      rem_shift;
    logic                rem_ge;

    // brightness tops out at 255, two guard bits cover the sum
    assign bright = {2'b00, div3(s_pix_red)} + {2'b00, div3(s_pix_green)}
                  + {2'b00, div3(s_pix_blue)};
    assign dark    = bright < {2'b00, thresh_reg};
    assign in_row  = col_reg < COL_W'(ROW_WIDTH);
    assign counted = in_row && !dark && (bright != '0);

    assign th_red   = dark ? '0 : s_pix_red;
    assign th_green = dark ? '0 : s_pix_green;
    assign th_blue  = dark ? '0 : s_pix_blue;

    always_comb begin
        col_next = col_reg + COL_W'(in_row);
        sum_next = sum_reg + (counted ? SUM_W'(col_reg) : '0);
        cnt_next = cnt_reg + COL_W'(counted);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.accept) begin
            if (s_row_end) begin
                col_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                col_reg <= col_next;
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // restoring divide, one quotient bit per step, MSB first
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};
    assign stat.div_last = step_reg == STEP_W'(SUM_W - 1);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            hold_red_reg   <= th_red;
            hold_green_reg <= th_green;
            hold_blue_reg  <= th_blue;
            div_reg        <= cnt_next;
            quo_reg        <= sum_next;
            rem_reg        <= '0;
            step_reg       <= '0;
        end else if (cmd.div_step) begin
            quo_reg  <= (quo_reg << 1) | SUM_W'(rem_ge);
            rem_reg  <= COL_W'(rem_ge ? rem_shift - {1'b0, div_reg} : rem_shift);
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            m_out_red     <= th_red;
            m_out_green   <= th_green;
            m_out_blue    <= th_blue;
            m_row_done    <= 1'b0;
            m_line_found  <= 1'b0;
            m_line_column <= '0;
        end else if (cmd.load_row) begin
            m_out_red     <= hold_red_reg;
            m_out_green   <= hold_green_reg;
            m_out_blue    <= hold_blue_reg;
            m_row_done    <= 1'b1;
            m_line_found  <= div_reg != '0;
            m_line_column <= (div_reg != '0) ? LINE_COL_W'(quo_reg) : '0;
        end
    end

endmodule

@@ rtl/core/row_bright_pixel_centroid.sv @@
// Top level of the row bright-pixel centroid block.
// Mid-row word: result in the output register the cycle after accept, one word per cycle
//   while the output is free or drained and no row end runs. Row-end word: the bit-serial
//   divider forms sum / count, then the result is loaded; no input word is taken meanwhile.
// Reset (aresetn low, synchronous): row accumulators clear, threshold returns to 150,
//   output goes invalid. No clearing pass; the block is ready the cycle after reset.
module row_bright_pixel_centroid
    import rbpc_pkg::*;
#(
    parameter int ROW_WIDTH = RBPC_ROW_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // threshold register write
    input  logic                  cfg_wr_en,
    input  logic [THRESH_W-1:0]   cfg_wr_data,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAN_W-1:0]     s_pix_red,
    input  logic [CHAN_W-1:0]     s_pix_green,
    input  logic [CHAN_W-1:0]     s_pix_blue,
    input  logic                  s_row_end,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAN_W-1:0]     m_out_red,
    output logic [CHAN_W-1:0]     m_out_green,
    output logic [CHAN_W-1:0]     m_out_blue,
    output logic                  m_row_done,
    output logic                  m_line_found,
    output logic [LINE_COL_W-1:0] m_line_column
);

    rbpc_cmd_t  cmd;
    rbpc_stat_t stat;

    // Controller: owns the handshakes; idle state takes a word whenever the
    // output register is free or being drained, row ends run the divider.
    rbpc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_row_end (s_row_end),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: threshold compare, column/sum/count accumulators, divider,
    // and the output register.
    rbpc_datapath #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_pix_red     (s_pix_red),
        .s_pix_green   (s_pix_green),
        .s_pix_blue    (s_pix_blue),
        .s_row_end     (s_row_end),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_row_done    (m_row_done),
        .m_line_found  (m_line_found),
        .m_line_column (m_line_column),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
